// File: src/lin_frame_monitor_defines.svh
// assertion macros shared by the lin frame monitor rtl
// expects signals named clock and reset in the including module
`ifndef LIN_FRAME_MONITOR_DEFINES_SVH
`define LIN_FRAME_MONITOR_DEFINES_SVH

// condition holds at every edge out of reset
`define LFM_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("lin frame monitor check failed");

// consequence holds in the same cycle as the antecedent
`define LFM_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lin frame monitor check failed");

// consequence holds in the cycle after the antecedent
`define LFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lin frame monitor check failed");

`endif

// File: src/lfm_pkg.sv
// lin frame monitor package: event codes, frame constants and pid helpers
// no dependencies
package lfm_pkg;

   localparam int KIND_BITS = 4;

   localparam logic [KIND_BITS-1:0] EVT_BREAK       = 4'd0;
   localparam logic [KIND_BITS-1:0] EVT_SHORT_BREAK = 4'd1;
   localparam logic [KIND_BITS-1:0] EVT_SYNC        = 4'd2;
   localparam logic [KIND_BITS-1:0] EVT_SYNC_ERR    = 4'd3;
   localparam logic [KIND_BITS-1:0] EVT_PID         = 4'd4;
   localparam logic [KIND_BITS-1:0] EVT_PID_ERR     = 4'd5;
   localparam logic [KIND_BITS-1:0] EVT_DATA        = 4'd6;
   localparam logic [KIND_BITS-1:0] EVT_CHECKSUM    = 4'd7;
   localparam logic [KIND_BITS-1:0] EVT_CHECKSUM_ERR = 4'd8;
   localparam logic [KIND_BITS-1:0] EVT_FRAME       = 4'd9;
   localparam logic [KIND_BITS-1:0] EVT_FRAME_ERR   = 4'd10;

   localparam logic [7:0] SYNC_BYTE     = 8'h55;
   localparam logic [7:0] ID_MASK       = 8'h3F;
   localparam logic [7:0] PARITY_MASK   = 8'hC0;
   localparam logic [5:0] CLASSIC_ID_A  = 6'd60;
   localparam logic [5:0] CLASSIC_ID_B  = 6'd61;
   localparam logic [5:0] LONG_FRAME_ID = 6'd48;
   localparam logic [5:0] MID_FRAME_ID  = 6'd32;
   localparam int         BREAK_BITS    = 13;
   localparam int         BYTE_BITS     = 10;
   localparam int         DATA_BITS     = 8;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [7:0]           value;
      logic [7:0]           sum;
      logic [2:0]           index;
      logic                 last;
   } rsp_info_type;

   // expected parity bits in place (bits 7:6)
   function automatic logic [7:0] pid_parity(input logic [7:0] p);
      logic p0;
      logic p1;
      p0 = p[0] ^ p[1] ^ p[2] ^ p[4];
      p1 = ~(p[1] ^ p[3] ^ p[4] ^ p[5]);
      return {p1, p0, 6'd0};
   endfunction

   function automatic logic [3:0] frame_length_for(input logic [7:0] p);
      logic [5:0] id;
      id = p[5:0];
      if (id >= LONG_FRAME_ID)
         return 4'd8;
      else if (id >= MID_FRAME_ID)
         return 4'd4;
      return 4'd2;
   endfunction

   // add with end-around carry
   function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[8])
         return s[7:0] + 8'd1;
      return s[7:0];
   endfunction

endpackage

// File: src/lin_frame_monitor.sv
// lin frame monitor top level: break hunt, uart byte sampling, frame checks
// depends on lfm_pkg and lin_frame_monitor_defines.svh
//
// req channel: one sampled line level per item in req_tdata[0], 1 is recessive.
// each accepted item advances the sample counter; stamps are sample counts.
// csr channel: writes bit_time (samples per lin bit), always ready; write it
// only while no item is in flight. bit_time of zero freezes frame tracking.
// rsp channel: zero, one or two event items per sample, rsp_tlast on the
// final one. a checksum byte gives the checksum event and then the frame event.
// each sample is handled in the cycle it is accepted and its events are registered
// into the result queue; one sample per cycle is taken as long as the
// four-entry result queue has room for two items, so with rsp_tready high
// the block runs at one sample per cycle indefinitely.
// when rsp stalls the queue fills and req_tready drops at fewer than two free entries.
// reset: hunting for a break, line taken as idle high, sample count zero,
// bit_time back to 104, queue empty.
module lin_frame_monitor #(
   parameter int STAMP_BITS    = 48,
   parameter int BIT_TIME_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,  // line_level
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // byte_value, expected_sum, data_index, start_stamp, end_stamp
   output logic [((19 + 2 * STAMP_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [lfm_pkg::KIND_BITS-1:0]             rsp_tuser,  // event_kind
   output logic                                      rsp_tlast,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [BIT_TIME_BITS-1:0]                  csr_data    // bit_time
);
   import lfm_pkg::*;

   `include "lin_frame_monitor_defines.svh"

   localparam int RspDataW  = ((19 + 2 * STAMP_BITS + 7) / 8) * 8;
   localparam int OffW      = BIT_TIME_BITS + 4;
   localparam int FifoDepth = 4;
   localparam int PtrW      = 2;
   localparam int CntW      = 3;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_BREAK = 3'd1;
   localparam logic [2:0] PH_SYNC  = 3'd2;
   localparam logic [2:0] PH_PID   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_SUM   = 3'd5;

   // frame tracking state
   logic [BIT_TIME_BITS-1:0] bit_time_ff, bit_time_in;
   logic [2:0]               phase_ff, phase_in;
   logic                     prev_level_ff, prev_level_in;
   logic [STAMP_BITS-1:0]    sample_count_ff, sample_count_in;
   logic [STAMP_BITS-1:0]    break_start_ff, break_start_in;
   logic [STAMP_BITS-1:0]    byte_start_ff, byte_start_in;
   logic                     byte_busy_ff, byte_busy_in;
   logic [OffW-1:0]          sample_offset_ff, sample_offset_in;
   logic [3:0]               bit_pos_ff, bit_pos_in;
   logic [7:0]               shift_byte_ff, shift_byte_in;
   logic [7:0]               stored_pid_ff, stored_pid_in;
   logic [3:0]               frame_len_ff, frame_len_in;
   logic [3:0]               data_count_ff, data_count_in;
   logic [7:0]               running_sum_ff, running_sum_in;

   // result queue
   rsp_info_type             fifo_info_ff [FifoDepth];
   logic [STAMP_BITS-1:0]    fifo_ss_ff   [FifoDepth];
   logic [STAMP_BITS-1:0]    fifo_es_ff   [FifoDepth];
   logic [PtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]          count_ff, count_in;

   logic                     accept;
   logic                     pop;
   logic                     lvl;
   logic                     fall;
   logic                     rise;
   logic [1:0]               push_n;
   rsp_info_type             res0, res1;
   logic [STAMP_BITS-1:0]    res0_ss, res0_es, res1_ss, res1_es;
   logic [STAMP_BITS-1:0]    break_len;
   logic [STAMP_BITS-1:0]    byte_end;
   logic [OffW-1:0]          break_min;
   logic [OffW-1:0]          target;
   logic [OffW-1:0]          offset_next;
   logic [3:0]               dc_next;
   logic [7:0]               sum_base;
   logic [7:0]               expect_sum;
   logic                     sum_ok;
   logic                     par_ok;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff <= CntW'(FifoDepth - 2));
   assign csr_ready  = 1'b1;

   assign lvl  = req_tdata[0];
   assign fall = prev_level_ff && !lvl;
   assign rise = !prev_level_ff && lvl;

   assign break_len   = sample_count_ff - break_start_ff;
   assign break_min   = OffW'(bit_time_ff) * OffW'(BREAK_BITS);
   assign byte_end    = byte_start_ff + STAMP_BITS'(OffW'(bit_time_ff) * OffW'(BYTE_BITS));
   // mid-bit sample point of the current bit
   assign target      = OffW'(bit_time_ff) * OffW'(bit_pos_ff + 4'd1)
                        + OffW'(bit_time_ff >> 1);
   assign offset_next = sample_offset_ff + OffW'(1);
   assign dc_next     = data_count_ff + 4'd1;
   assign sum_base    = ((stored_pid_ff[5:0] == CLASSIC_ID_A) ||
                         (stored_pid_ff[5:0] == CLASSIC_ID_B))
                        ? running_sum_ff : carry_add(running_sum_ff, stored_pid_ff);
   assign expect_sum  = ~sum_base;
   assign sum_ok      = (shift_byte_ff == expect_sum);
   assign par_ok      = ((stored_pid_ff & PARITY_MASK) == pid_parity(stored_pid_ff));

   always_comb begin
      bit_time_in      = bit_time_ff;
      phase_in         = phase_ff;
      prev_level_in    = prev_level_ff;
      sample_count_in  = sample_count_ff;
      break_start_in   = break_start_ff;
      byte_start_in    = byte_start_ff;
      byte_busy_in     = byte_busy_ff;
      sample_offset_in = sample_offset_ff;
      bit_pos_in       = bit_pos_ff;
      shift_byte_in    = shift_byte_ff;
      stored_pid_in    = stored_pid_ff;
      frame_len_in     = frame_len_ff;
      data_count_in    = data_count_ff;
      running_sum_in   = running_sum_ff;
      push_n           = 2'd0;
      res0             = '0;
      res1             = '0;
      res0_ss          = '0;
      res0_es          = '0;
      res1_ss          = '0;
      res1_es          = '0;

      if (csr_valid && csr_ready) begin
         bit_time_in = csr_data;
      end

      if (accept) begin
         prev_level_in   = lvl;
         sample_count_in = sample_count_ff + STAMP_BITS'(1);
         if (bit_time_ff != '0) begin
            unique case (phase_ff) inside
               PH_HUNT: begin
                  if (fall) begin
                     break_start_in = sample_count_ff;
                     phase_in       = PH_BREAK;
                  end
               end
               PH_BREAK: begin
                  if (rise) begin
                     push_n    = 2'd1;
                     res0.last = 1'b1;
                     res0_ss   = break_start_ff;
                     res0_es   = sample_count_ff;
                     if (break_len >= STAMP_BITS'(break_min)) begin
                        res0.kind = EVT_BREAK;
                        phase_in  = PH_SYNC;
                     end else begin
                        res0.kind = EVT_SHORT_BREAK;
                        phase_in  = PH_HUNT;
                     end
                  end
               end
               PH_SYNC, PH_PID, PH_DATA, PH_SUM: begin
                  if (!byte_busy_ff) begin
                     if (fall) begin
                        byte_busy_in     = 1'b1;
                        byte_start_in    = sample_count_ff;
                        sample_offset_in = '0;
                        bit_pos_in       = 4'd0;
                        shift_byte_in    = 8'd0;
                     end
                  end else begin
                     sample_offset_in = offset_next;
                     if (offset_next >= target) begin
                        if (bit_pos_ff < 4'(DATA_BITS)) begin
                           shift_byte_in[bit_pos_ff[2:0]] = shift_byte_ff[bit_pos_ff[2:0]] | lvl;
                           bit_pos_in = bit_pos_ff + 4'd1;
                        end else begin
                           byte_busy_in = 1'b0;
                           if (!lvl) begin
                              // framing error on the stop bit drops the frame quietly
                              phase_in = PH_HUNT;
                           end else begin
                              push_n     = 2'd1;
                              res0.value = shift_byte_ff;
                              res0.last  = 1'b1;
                              res0_ss    = byte_start_ff;
                              res0_es    = byte_end;
                              unique case (phase_ff)
                                 PH_SYNC: begin
                                    if (shift_byte_ff == SYNC_BYTE) begin
                                       res0.kind = EVT_SYNC;
                                       phase_in  = PH_PID;
                                    end else begin
                                       res0.kind = EVT_SYNC_ERR;
                                       phase_in  = PH_HUNT;
                                    end
                                 end
                                 PH_PID: begin
                                    stored_pid_in  = shift_byte_ff;
                                    frame_len_in   = frame_length_for(shift_byte_ff);
                                    data_count_in  = 4'd0;
                                    running_sum_in = 8'd0;
                                    res0.kind = ((shift_byte_ff & PARITY_MASK) ==
                                                 pid_parity(shift_byte_ff))
                                                ? EVT_PID : EVT_PID_ERR;
                                    phase_in  = PH_DATA;
                                 end
                                 PH_DATA: begin
                                    res0.kind      = EVT_DATA;
                                    res0.index     = data_count_ff[2:0];
                                    running_sum_in = carry_add(running_sum_ff, shift_byte_ff);
                                    data_count_in  = dc_next;
                                    if (dc_next >= frame_len_ff) begin
                                       phase_in = PH_SUM;
                                    end
                                 end
                                 default: begin
                                    push_n     = 2'd2;
                                    res0.kind  = sum_ok ? EVT_CHECKSUM : EVT_CHECKSUM_ERR;
                                    res0.sum   = expect_sum;
                                    res0.last  = 1'b0;
                                    res1.kind  = (sum_ok && par_ok) ? EVT_FRAME : EVT_FRAME_ERR;
                                    res1.value = stored_pid_ff;
                                    res1.last  = 1'b1;
                                    res1_ss    = break_start_ff;
                                    res1_es    = byte_end;
                                    phase_in   = PH_HUNT;
                                 end
                              endcase
                           end
                        end
                     end
                  end
               end
               default: begin
                  phase_in = PH_HUNT;
               end
            endcase
         end
      end
   end

   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + CntW'(push_n) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff      <= BIT_TIME_BITS'(104);
         phase_ff         <= PH_HUNT;
         prev_level_ff    <= 1'b1;
         sample_count_ff  <= '0;
         break_start_ff   <= '0;
         byte_start_ff    <= '0;
         byte_busy_ff     <= 1'b0;
         sample_offset_ff <= '0;
         bit_pos_ff       <= 4'd0;
         shift_byte_ff    <= 8'd0;
         stored_pid_ff    <= 8'd0;
         frame_len_ff     <= 4'd0;
         data_count_ff    <= 4'd0;
         running_sum_ff   <= 8'd0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         bit_time_ff      <= bit_time_in;
         phase_ff         <= phase_in;
         prev_level_ff    <= prev_level_in;
         sample_count_ff  <= sample_count_in;
         break_start_ff   <= break_start_in;
         byte_start_ff    <= byte_start_in;
         byte_busy_ff     <= byte_busy_in;
         sample_offset_ff <= sample_offset_in;
         bit_pos_ff       <= bit_pos_in;
         shift_byte_ff    <= shift_byte_in;
         stored_pid_ff    <= stored_pid_in;
         frame_len_ff     <= frame_len_in;
         data_count_ff    <= data_count_in;
         running_sum_ff   <= running_sum_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
   end

   // queue payload, up to two items written per cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < FifoDepth; i++) begin
         if ((push_n != 2'd0) && (PtrW'(i) == wr_ptr_ff)) begin
            fifo_info_ff[i] <= res0;
            fifo_ss_ff[i]   <= res0_ss;
            fifo_es_ff[i]   <= res0_es;
         end else if ((push_n == 2'd2) && (PtrW'(i) == wr_ptr_ff + PtrW'(1))) begin
            fifo_info_ff[i] <= res1;
            fifo_ss_ff[i]   <= res1_ss;
            fifo_es_ff[i]   <= res1_es;
         end
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = fifo_info_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = fifo_info_ff[rd_ptr_ff].last;
   assign rsp_tdata  = RspDataW'({fifo_es_ff[rd_ptr_ff], fifo_ss_ff[rd_ptr_ff],
                                  fifo_info_ff[rd_ptr_ff].index,
                                  fifo_info_ff[rd_ptr_ff].sum,
                                  fifo_info_ff[rd_ptr_ff].value});

   `LFM_ASSERT_ALWAYS(a_queue_bound, count_ff <= CntW'(FifoDepth))
   `LFM_ASSERT_NEXT(a_queue_count, 1'b1, count_ff == $past(count_in))
   `LFM_ASSERT_IMPLIES(a_idle_byte, (phase_ff == PH_HUNT) || (phase_ff == PH_BREAK), !byte_busy_ff)
   `LFM_ASSERT_ALWAYS(a_bit_pos, bit_pos_ff <= 4'(DATA_BITS))

endmodule

// File: verif/testbench.sv
// testbench for lin_frame_monitor: drives sampled line levels as lin frames and
// checks every event item against a cycle-free predictor kept in this file
// depends on lfm_pkg and the lin_frame_monitor rtl
`timescale 1ns / 1ps

module testbench;
   import lfm_pkg::*;

   localparam int STAMP_W = 48;
   localparam int BT_W    = 16;
   localparam int RSP_W   = ((19 + 2 * STAMP_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      HUNT_IDLE, HUNT_LOW, WAIT_SYNC, WAIT_PID, WAIT_DATA, WAIT_SUM
   } hunt_state_t;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [7:0]           value;
      logic [7:0]           sum;
      logic [2:0]           index;
      logic [STAMP_W-1:0]   opened;
      logic [STAMP_W-1:0]   closed;
      logic                 last;
   } lin_event_t;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = 8'd0;    // line_level
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;            // byte_value, expected_sum, data_index,
                                            // start_stamp, end_stamp
   logic [KIND_BITS-1:0] rsp_tuser;         // event_kind
   logic              rsp_tlast;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [BT_W-1:0]   csr_data   = '0;      // bit_time

   lin_frame_monitor #(
      .STAMP_BITS    (STAMP_W),
      .BIT_TIME_BITS (BT_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state of the monitor
   logic [BT_W-1:0]    bit_len;
   hunt_state_t        hunt;
   logic               prev_level;
   logic [STAMP_W-1:0] sample_no;
   logic [STAMP_W-1:0] break_at;
   logic [STAMP_W-1:0] byte_at;
   logic               in_byte;
   int unsigned        offset;
   logic [3:0]         bit_no;
   logic [7:0]         shifter;
   logic [7:0]         frame_pid;
   logic [3:0]         data_len;
   logic [3:0]         data_seen;
   logic [7:0]         sum_acc;

   lin_event_t expected_events[$];
   lin_event_t step_events[$];

   logic [7:0] frame_bytes [0:7];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int byte_gap_max    = 0;
   int holdoff_request = 0;
   int holdoff_left    = 0;
   int error_count     = 0;
   int events_checked  = 0;
   int events_predicted = 0;
   int samples_sent    = 0;
   int stall_cycles    = 0;

   function automatic logic [1:0] parity_of(input logic [7:0] p);
      return {~(p[1] ^ p[3] ^ p[4] ^ p[5]), p[0] ^ p[1] ^ p[2] ^ p[4]};
   endfunction

   function automatic logic [7:0] with_parity(input logic [5:0] id);
      logic [7:0] p;
      p = {2'b00, id};
      p[7:6] = parity_of(p);
      return p;
   endfunction

   function automatic logic [3:0] data_bytes_for(input logic [7:0] p);
      if (p[5:0] >= LONG_FRAME_ID)
         return 4'd8;
      if (p[5:0] >= MID_FRAME_ID)
         return 4'd4;
      return 4'd2;
   endfunction

   function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[7:0] + {7'd0, s[8]};
   endfunction

   function automatic logic is_classic(input logic [7:0] p);
      return (p[5:0] == CLASSIC_ID_A) || (p[5:0] == CLASSIC_ID_B);
   endfunction

   function automatic logic [7:0] frame_checksum(input logic [7:0] pid, input int n);
      logic [7:0] s;
      s = is_classic(pid) ? 8'd0 : pid;
      for (int k = 0; k < n; k++)
         s = ones_add(s, frame_bytes[k]);
      return ~s;
   endfunction

   task automatic add_event(input logic [KIND_BITS-1:0] kind, input logic [7:0] value,
                            input logic [7:0] sum, input logic [2:0] index,
                            input logic [STAMP_W-1:0] opened,
                            input logic [STAMP_W-1:0] closed);
      lin_event_t e;
      e = '{kind, value, sum, index, opened, closed, 1'b0};
      step_events.push_back(e);
   endtask

   task automatic close_byte(input logic [7:0] val);
      logic [STAMP_W-1:0] closed;
      logic [7:0] s;
      logic [7:0] want;
      logic good_sum;
      closed = byte_at + STAMP_W'(bit_len) * STAMP_W'(BYTE_BITS);
      case (hunt)
         WAIT_SYNC: begin
            if (val == SYNC_BYTE) begin
               add_event(EVT_SYNC, val, 8'd0, 3'd0, byte_at, closed);
               hunt = WAIT_PID;
            end else begin
               add_event(EVT_SYNC_ERR, val, 8'd0, 3'd0, byte_at, closed);
               hunt = HUNT_IDLE;
            end
         end
         WAIT_PID: begin
            frame_pid = val;
            data_len  = data_bytes_for(val);
            data_seen = 4'd0;
            sum_acc   = 8'd0;
            add_event((parity_of(val) == val[7:6]) ? EVT_PID : EVT_PID_ERR,
                      val, 8'd0, 3'd0, byte_at, closed);
            hunt = WAIT_DATA;
         end
         WAIT_DATA: begin
            add_event(EVT_DATA, val, 8'd0, data_seen[2:0], byte_at, closed);
            sum_acc   = ones_add(sum_acc, val);
            data_seen = data_seen + 4'd1;
            if (data_seen >= data_len)
               hunt = WAIT_SUM;
         end
         default: begin
            s = is_classic(frame_pid) ? sum_acc : ones_add(sum_acc, frame_pid);
            want = ~s;
            good_sum = (val == want);
            add_event(good_sum ? EVT_CHECKSUM : EVT_CHECKSUM_ERR, val, want, 3'd0,
                      byte_at, closed);
            add_event((good_sum && parity_of(frame_pid) == frame_pid[7:6]) ?
                      EVT_FRAME : EVT_FRAME_ERR, frame_pid, 8'd0, 3'd0, break_at, closed);
            hunt = HUNT_IDLE;
         end
      endcase
   endtask

   // works out the events that one accepted line sample causes
   task automatic predict_sample(input logic level);
      logic fall;
      logic rise;
      logic [STAMP_W-1:0] low_len;
      int unsigned target;
      fall = prev_level && !level;
      rise = !prev_level && level;
      step_events.delete();
      if (bit_len != 0) begin
         case (hunt)
            HUNT_IDLE: begin
               if (fall) begin
                  break_at = sample_no;
                  hunt = HUNT_LOW;
               end
            end
            HUNT_LOW: begin
               if (rise) begin
                  low_len = sample_no - break_at;
                  if (64'(low_len) >= 64'(bit_len) * 64'(BREAK_BITS)) begin
                     add_event(EVT_BREAK, 8'd0, 8'd0, 3'd0, break_at, sample_no);
                     hunt = WAIT_SYNC;
                  end else begin
                     add_event(EVT_SHORT_BREAK, 8'd0, 8'd0, 3'd0, break_at, sample_no);
                     hunt = HUNT_IDLE;
                  end
               end
            end
            default: begin
               if (!in_byte) begin
                  if (fall) begin
                     in_byte = 1'b1;
                     byte_at = sample_no;
                     offset  = 0;
                     bit_no  = 4'd0;
                     shifter = 8'd0;
                  end
               end else begin
                  target = int'(bit_len) * (int'(bit_no) + 1) + int'(bit_len) / 2;
                  offset++;
                  if (offset >= target) begin
                     if (bit_no < DATA_BITS) begin
                        shifter[bit_no[2:0]] = level;
                        bit_no = bit_no + 4'd1;
                     end else begin
                        in_byte = 1'b0;
                        // a low stop bit drops the frame without an item
                        if (!level)
                           hunt = HUNT_IDLE;
                        else
                           close_byte(shifter);
                     end
                  end
               end
            end
         endcase
      end
      prev_level = level;
      sample_no  = sample_no + 1'b1;
      if (step_events.size() > 0)
         step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[k])
         expected_events.push_back(step_events[k]);
      events_predicted += step_events.size();
   endtask

   task automatic send_sample(input logic level);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_sample(level);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_run(input logic level, input int count);
      for (int k = 0; k < count; k++)
         send_sample(level);
   endtask

   task automatic send_byte(input logic [7:0] val, input logic stop_level);
      send_run(1'b0, bit_len);
      for (int k = 0; k < DATA_BITS; k++)
         send_run(val[k], bit_len);
      send_run(stop_level, bit_len);
      send_run(1'b1, $urandom_range(0, byte_gap_max));
   endtask

   // long low pulses, at most four of them, until the hunt is back to waiting for a break
   task automatic flush_hunt;
      int tries;
      tries = 0;
      while ((hunt != HUNT_IDLE || in_byte) && tries < 4) begin
         send_run(1'b0, 11 * bit_len);
         send_run(1'b1, 2 * bit_len);
         tries++;
      end
   endtask

   task automatic send_frame(input logic [7:0] sync_val, input logic [7:0] pid_val,
                             input int low_len, input logic [7:0] sum_flip,
                             input int bad_stop);
      int n;
      logic [7:0] sum_val;
      n = data_bytes_for(pid_val);
      sum_val = frame_checksum(pid_val, n) ^ sum_flip;
      flush_hunt();
      send_run(1'b1, bit_len + $urandom_range(0, bit_len));
      send_run(1'b0, low_len);
      send_run(1'b1, $urandom_range(1, 2 * bit_len));
      send_byte(sync_val, bad_stop != 0);
      send_byte(pid_val, bad_stop != 1);
      for (int k = 0; k < n; k++)
         send_byte(frame_bytes[k], bad_stop != k + 2);
      send_byte(sum_val, bad_stop != n + 2);
      send_run(1'b1, bit_len);
   endtask

   task automatic fill_data;
      for (int k = 0; k < 8; k++) begin
         case ($urandom_range(9))
            0:       frame_bytes[k] = 8'h00;
            1:       frame_bytes[k] = 8'hFF;
            default: frame_bytes[k] = 8'($urandom);
         endcase
      end
   endtask

   // drop valid and wait until every expected item has come out
   task automatic settle;
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bit_time(input logic [BT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      bit_len = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_bit_time;
      send_run(1'b1, 20);
      // one sample short of a break at the reset bit time
      send_run(1'b0, BREAK_BITS * bit_len - 1);
      send_run(1'b1, 50);
      fill_data();
      send_frame(SYNC_BYTE, with_parity(6'd16), BREAK_BITS * bit_len, 8'd0, -1);
   endtask

   task automatic test_frame_checks;
      write_bit_time(2);
      frame_bytes[0] = 8'h00;
      frame_bytes[1] = 8'hFF;
      send_frame(SYNC_BYTE, with_parity(6'd0), BREAK_BITS * 2, 8'd0, -1);
      fill_data();
      send_frame(8'h54, with_parity(6'd17), 28, 8'd0, -1);
      send_frame(SYNC_BYTE, with_parity(6'd5) ^ 8'h40, 28, 8'd0, -1);
      send_frame(SYNC_BYTE, with_parity(6'd32), 28, 8'd0, -1);
      fill_data();
      send_frame(SYNC_BYTE, with_parity(6'd48), 28, 8'd0, -1);
      send_frame(SYNC_BYTE, with_parity(CLASSIC_ID_A), 28, 8'd0, -1);
      fill_data();
      send_frame(SYNC_BYTE, with_parity(CLASSIC_ID_B), 30, 8'd0, -1);
      send_frame(SYNC_BYTE, with_parity(6'd47), 28, 8'h01, -1);
      send_frame(SYNC_BYTE, with_parity(6'd63), 28, 8'd0, 3);
      flush_hunt();
      send_run(1'b1, 4);
      send_run(1'b0, BREAK_BITS * 2 - 1);
      send_run(1'b1, 4);
   endtask

   task automatic test_bit_time_limits;
      flush_hunt();
      // frozen tracking: levels toggle but nothing comes out
      write_bit_time(0);
      for (int k = 0; k < 40; k++)
         send_sample((k % 3 == 0) ? 1'b0 : 1'($urandom));
      send_run(1'b1, 4);
      write_bit_time(1);
      fill_data();
      send_frame(SYNC_BYTE, with_parity(6'd36), BREAK_BITS, 8'd0, -1);
      flush_hunt();
      write_bit_time(16'hFFFF);
      send_run(1'b1, 5);
      send_run(1'b0, 200);
      send_run(1'b1, 5);
   endtask

   task automatic test_mid_byte_retiming;
      logic [7:0] pid;
      write_bit_time(4);
      pid = with_parity(6'd9);
      send_run(1'b1, 8);
      send_run(1'b0, BREAK_BITS * 4 + 2);
      send_run(1'b1, 4);
      send_byte(SYNC_BYTE, 1'b1);
      send_run(1'b0, 4);
      for (int k = 0; k < 4; k++)
         send_run(pid[k], 4);
      // bit time changes while the pid byte is half received
      write_bit_time(6);
      for (int k = 4; k < DATA_BITS; k++)
         send_run(pid[k], 4);
      send_run(1'b1, 24);
      flush_hunt();
   endtask

   task automatic test_result_backpressure;
      write_bit_time(2);
      fill_data();
      holdoff_request = 400;
      send_frame(SYNC_BYTE, with_parity(6'd58), 30, 8'd0, -1);
   endtask

   task automatic send_random_frame;
      int r;
      int n;
      logic [7:0] sync_val;
      logic [7:0] pid_val;
      logic [7:0] flip;
      int bad;
      r = $urandom_range(99);
      if (r < 6) begin
         flush_hunt();
         send_run(1'b1, $urandom_range(1, 2 * bit_len));
         send_run(1'b0, $urandom_range(1, BREAK_BITS * bit_len - 1));
         send_run(1'b1, bit_len);
      end else if (r < 10) begin
         repeat ($urandom_range(4, 40))
            send_sample(1'($urandom));
      end else begin
         sync_val = ($urandom_range(99) < 5) ? 8'($urandom) : SYNC_BYTE;
         pid_val = with_parity(6'($urandom));
         if ($urandom_range(99) < 10)
            pid_val = with_parity(($urandom_range(1) != 0) ? CLASSIC_ID_A : CLASSIC_ID_B);
         if ($urandom_range(99) < 8)
            pid_val[7:6] = pid_val[7:6] ^ 2'($urandom_range(1, 3));
         n = data_bytes_for(pid_val);
         flip = ($urandom_range(99) < 8) ? 8'($urandom_range(1, 255)) : 8'd0;
         bad = ($urandom_range(99) < 4) ? $urandom_range(0, n + 2) : -1;
         fill_data();
         send_frame(sync_val, pid_val,
                    BREAK_BITS * bit_len + $urandom_range(0, 3 * bit_len), flip, bad);
      end
   endtask

   task automatic test_random_traffic;
      int phase_bits [4]  = '{3, 2, 5, 4};
      int phase_send [4]  = '{0, 54, 0, 19};
      int phase_recv [4]  = '{0, 0, 54, 19};
      int start_samples;
      int start_events;
      start_events = events_predicted;
      for (int ph = 0; ph < 4; ph++) begin
         write_bit_time(phase_bits[ph]);
         send_idle_pct  = phase_send[ph];
         recv_stall_pct = phase_recv[ph];
         byte_gap_max   = phase_bits[ph];
         start_samples  = samples_sent;
         while (samples_sent - start_samples < 375)
            send_random_frame();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (events_predicted - start_events < 60)
         send_random_frame();
   endtask

   // receiver side: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (holdoff_request > 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready)
         stall_cycles++;
   end

   task automatic compare_field(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 200)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      lin_event_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            error_count++;
            if (error_count <= 200)
               $display("%0t: unexpected item, expected none, got kind %0d value 0x%0h",
                        $time, rsp_tuser, rsp_tdata[7:0]);
         end else begin
            want = expected_events.pop_front();
            compare_field("event_kind", want.kind, rsp_tuser);
            compare_field("byte_value", want.value, rsp_tdata[7:0]);
            compare_field("expected_sum", want.sum, rsp_tdata[15:8]);
            compare_field("data_index", want.index, rsp_tdata[18:16]);
            compare_field("start_stamp", want.opened, rsp_tdata[19 +: STAMP_W]);
            compare_field("end_stamp", want.closed, rsp_tdata[19 + STAMP_W +: STAMP_W]);
            compare_field("last", want.last, rsp_tlast);
            events_checked++;
         end
      end
   end

   initial begin
      bit_len    = 16'd104;
      hunt       = HUNT_IDLE;
      prev_level = 1'b1;
      sample_no  = '0;
      break_at   = '0;
      byte_at    = '0;
      in_byte    = 1'b0;
      offset     = 0;
      bit_no     = 4'd0;
      shifter    = 8'd0;
      frame_pid  = 8'd0;
      data_len   = 4'd0;
      data_seen  = 4'd0;
      sum_acc    = 8'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_bit_time();
      test_frame_checks();
      test_bit_time_limits();
      test_mid_byte_retiming();
      test_result_backpressure();
      test_random_traffic();

      settle();
      repeat (10) @(negedge clock);
      if (expected_events.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected items never came out", $time, expected_events.size());
      end
      $display("checked %0d event items from %0d line samples, bit times 0 to 65535",
               events_checked, samples_sent);
      $display("sample input was held back for %0d cycles by result backpressure",
               stall_cycles);
      if (error_count == 0)
         $display("PASS lin_frame_monitor");
      else
         $display("FAIL lin_frame_monitor");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL lin_frame_monitor");
      $finish;
   end

endmodule
